>>> hw/rtl/hva_pkg.sv
package hva_pkg;

  // Accumulator geometry
  localparam int R_BINS   = 512;
  localparam int RBIN_W   = $clog2(R_BINS);
  localparam int ROW_W    = 8;
  localparam int ADDR_W   = ROW_W + RBIN_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;

  // Field and datapath widths
  localparam int SPREAD_W = 5;
  localparam int STEP_W   = SPREAD_W + 1;
  localparam int CNT_W    = 16;
  localparam int PT_W     = 9;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = 25;
  localparam int Q_SHIFT  = 14;
  localparam int RAD_W    = PROD_W - Q_SHIFT;
  localparam int RI_W     = RAD_W + 1;

  localparam logic [SPREAD_W-1:0] SPREAD_RESET = SPREAD_W'(5);
  localparam logic [CNT_W-1:0]    COUNT_MAX    = '1;

  typedef enum logic [1:0] {
    MODE_VOTE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RAD,
    ST_RANGE,
    ST_BIN,
    ST_WR,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_DONE
  } state_t;

  // First quadrant of sine, Q2.14, entries 0..64
  localparam logic [14:0] QSINE [65] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
    15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
    15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
    15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
    15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
    15'd13623, 15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811, 15'd14978,
    15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679, 15'd15791, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
    15'd16384
  };

  // Full-turn sine from the quarter table by symmetry
  function automatic logic signed [COEF_W-1:0] sine_q14(input logic [ROW_W-1:0] a);
    logic [6:0]               idx;
    logic signed [COEF_W-1:0] v;
    idx = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
    v   = {1'b0, QSINE[idx]};
    return a[7] ? -v : v;
  endfunction

endpackage

>>> hw/rtl/hva_item_if.sv
interface hva_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic signed [8:0] point_x;
  logic signed [8:0] point_y;
  logic [7:0] angle;
  logic [8:0] radius_bin;

  modport source (output valid, mode, point_x, point_y, angle, radius_bin, input ready);
  modport sink   (input valid, mode, point_x, point_y, angle, radius_bin, output ready);
endinterface

>>> hw/rtl/hva_result_if.sv
interface hva_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] bin_count;
  logic        saturated;

  modport source (output valid, bin_count, saturated, input ready);
  modport sink   (input valid, bin_count, saturated, output ready);
endinterface

>>> hw/rtl/hva_ram.sv
module hva_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> hw/rtl/hough_vote_accumulator_core.sv
// Channel   Dir  Payload                                         Handshake
// item      in   mode, point_x, point_y, angle, radius_bin       valid/ready
// result    out  bin_count, saturated                            valid/ready
// spread    in   angle_spread_wdata (5b)                         angle_spread_we
//
// Vote: per angle row (2*spread+1 rows), the next radius is formed on the shared
//   multiplier and range step, then each in-range bin gets a read-modify-write on the
//   count RAM; a clipped bin is stepped past without a write.
// Read: RAM address, then data. Clear: 2**(8+RBIN_W) words, one RAM word per sweep cycle.
// After rst the same clearing sweep runs before the first item is taken.
// One item at a time; a finished result waits in the output register while the
// next item is accepted.
module hough_vote_accumulator_core (
  input  logic                         clk,
  input  logic                         rst,
  hva_item_if.sink                     item,
  hva_result_if.source                 result,
  input  logic                         angle_spread_we,
  input  logic [hva_pkg::SPREAD_W-1:0] angle_spread_wdata
);
  import hva_pkg::*;

  localparam logic signed [RI_W-1:0] RI_OFFSET = RI_W'(R_BINS / 2);
  localparam logic signed [RI_W-1:0] RI_LIMIT  = RI_W'(R_BINS);

  state_t state, state_next;

  // Control registers
  logic [SPREAD_W-1:0] spread;
  logic [1:0]          mstep;
  logic                first_rad;
  logic [ADDR_W-1:0]   sweep;
  logic                clr_reply;
  logic                out_valid;

  // Datapath registers
  logic signed [PT_W-1:0]   x_q, y_q;
  logic [ROW_W-1:0]         row, rad_ang;
  logic [STEP_W-1:0]        remain;
  logic [RBIN_W-1:0]        rbin_q;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod, acc;
  logic signed [RAD_W-1:0]  r0, r1, cur, hi_r;
  logic [ADDR_W-1:0]        addr_q;
  logic [CNT_W-1:0]         res_count, out_count;
  logic                     res_sat, out_sat;

  // Combinational
  logic                     accept, can_load, rbin_ok;
  logic signed [PT_W-1:0]   mul_a;
  logic signed [PROD_W-1:0] mul_out, rad_sum;
  logic signed [RAD_W-1:0]  rad_res;
  logic signed [RI_W-1:0]   ri;
  logic                     ri_ok, last_bin, last_row;
  logic [ADDR_W-1:0]        bin_addr, rd_addr, wr_addr;
  logic                     ram_we;
  logic [CNT_W-1:0]         wr_data, rd_data;

  hva_ram #(
    .WIDTH(CNT_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign accept   = item.valid && (state == ST_IDLE);
  assign can_load = !out_valid || result.ready;
  assign rbin_ok  = 32'(item.radius_bin) < 32'(R_BINS);

  // Shared multiplier: x*cos on step 1, y*sin on step 2
  assign mul_a   = (mstep == 2'd1) ? x_q : y_q;
  assign mul_out = mul_a * coef;
  assign rad_sum = acc + prod;
  assign rad_res = rad_sum[Q_SHIFT +: RAD_W];   // arithmetic floor of sum / 2**14

  // Bin addressing
  assign ri       = RI_W'(cur) + RI_OFFSET;
  assign ri_ok    = !ri[RI_W-1] && (ri < RI_LIMIT);
  assign bin_addr = {row, ri[RBIN_W-1:0]};
  assign last_bin = (cur == hi_r);
  assign last_row = (remain == STEP_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          unique case (item.mode)
            MODE_VOTE:  state_next = ST_RAD;
            MODE_READ:  state_next = rbin_ok ? ST_RD_ADDR : ST_DONE;
            MODE_CLEAR: state_next = ST_CLEAR;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (sweep == '1) begin
          state_next = clr_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_RAD: begin
        if (mstep == 2'd3 && !first_rad) begin
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: state_next = ST_BIN;
      ST_BIN: begin
        if (ri_ok) begin
          state_next = ST_WR;
        end else if (last_bin) begin
          state_next = last_row ? ST_DONE : ST_RAD;
        end
      end
      ST_WR: begin
        if (last_bin) begin
          state_next = last_row ? ST_DONE : ST_RAD;
        end else begin
          state_next = ST_BIN;
        end
      end
      ST_RD_ADDR: state_next = ST_RD_DATA;
      ST_RD_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and RAM controls
  always_comb begin
    item.ready       = (state == ST_IDLE);
    result.valid     = out_valid;
    result.bin_count = out_count;
    result.saturated = out_sat;
    rd_addr          = (state == ST_RD_ADDR) ? {row, rbin_q} : bin_addr;
    ram_we           = (state == ST_CLEAR) || ((state == ST_WR) && (rd_data != COUNT_MAX));
    wr_addr          = (state == ST_CLEAR) ? sweep : addr_q;
    wr_data          = (state == ST_CLEAR) ? '0 : rd_data + CNT_W'(1);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      spread    <= SPREAD_RESET;
      mstep     <= '0;
      first_rad <= 1'b0;
      sweep     <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (angle_spread_we) begin
        spread <= angle_spread_wdata;
      end
      mstep <= (state == ST_RAD) ? mstep + 2'd1 : 2'd0;
      if (accept) begin
        first_rad <= 1'b1;
        if (item.mode == MODE_CLEAR) begin
          clr_reply <= 1'b1;
        end
      end else if (state == ST_RAD && mstep == 2'd3) begin
        first_rad <= 1'b0;
      end
      if (state == ST_CLEAR) begin
        sweep <= sweep + ADDR_W'(1);
      end
      if (state == ST_DONE && can_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q       <= item.point_x;
      y_q       <= item.point_y;
      rbin_q    <= RBIN_W'(item.radius_bin);
      remain    <= {spread, 1'b1};
      rad_ang   <= item.angle - ROW_W'(spread);
      row       <= (item.mode == MODE_VOTE) ? item.angle - ROW_W'(spread) : item.angle;
      res_count <= '0;
      res_sat   <= 1'b0;
    end

    // Radius on the shared multiplier
    if (state == ST_RAD) begin
      unique case (mstep)
        2'd0: coef <= sine_q14(rad_ang + ROW_W'(64));
        2'd1: begin
          prod <= mul_out;
          coef <= sine_q14(rad_ang);
        end
        2'd2: begin
          acc  <= prod;
          prod <= mul_out;
        end
        2'd3: begin
          if (first_rad) begin
            r0      <= rad_res;
            rad_ang <= row + ROW_W'(1);
          end else begin
            r1 <= rad_res;
          end
        end
        default: ;
      endcase
    end

    // Span of radii between this row and the next
    if (state == ST_RANGE) begin
      cur  <= (r0 < r1) ? r0 : r1;
      hi_r <= (r0 < r1) ? r1 : r0;
    end

    if (state == ST_BIN) begin
      addr_q <= bin_addr;
    end
    if (state == ST_WR && rd_data == COUNT_MAX) begin
      res_sat <= 1'b1;
    end

    // Step to the next bin, or close the row
    if ((state == ST_BIN && !ri_ok) || state == ST_WR) begin
      if (last_bin) begin
        r0      <= r1;
        remain  <= remain - STEP_W'(1);
        row     <= row + ROW_W'(1);
        rad_ang <= row + ROW_W'(2);
      end else begin
        cur <= cur + RAD_W'(1);
      end
    end

    if (state == ST_RD_DATA) begin
      res_count <= rd_data;
    end

    if (state == ST_DONE && can_load) begin
      out_count <= res_count;
      out_sat   <= res_sat;
    end
  end

endmodule

>>> hw/rtl/hva_checker.sv
module hva_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] bin_count,
  input logic        saturated
);

  // Items taken but whose result has not been handed over
  logic [1:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 2'((in_valid && in_ready) ? 1 : 0)
                                 - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end

  // Ready is low straight after reset, when the clearing sweep begins
  a_no_accept_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("item ready right after reset");

  // Each accepted item makes the block busy: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready again right after an accepted item");

  // A result is never shown without an item behind it
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> outstanding != 2'd0)
    else $error("result without an outstanding item");

  // At most one result waiting and one item in flight
  a_outstanding_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding != 2'd3)
    else $error("too many outstanding items");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_count) && $stable(saturated))
    else $error("stalled result changed");

endmodule

bind hough_vote_accumulator_core hva_checker u_hva_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (item.valid),
  .in_ready (item.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .bin_count(result.bin_count),
  .saturated(result.saturated)
);

>>> tb/hough_vote_accumulator_core_tb.sv
`timescale 1ns / 1ps

module hough_vote_accumulator_core_tb;
  import hva_pkg::*;

  localparam int  ROWS         = 256;
  localparam int  HALF_BINS    = R_BINS / 2;
  localparam int  MAX_IDLE     = 18;
  localparam int  WATCHDOG     = 400000;  // clearing sweep covers 131072 RAM words
  localparam int  DRAIN_CYCLES = 32;
  localparam int  PHASES       = 8;
  localparam int  PHASE_ITEMS  = 190;
  localparam int  HIT_DEPTH    = 64;
  localparam int  FILL_ROW     = 10;
  localparam int  FILL_VOTES   = 40;
  localparam real PI           = 3.14159265358979323846;

  // mode 3 has no member in the package enum
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [CNT_W-1:0] count;
    logic             saturated;
  } bin_result_t;

  // Accumulator shadow: predicts each result at item acceptance, checks in order
  class accum_scoreboard;
    bit [CNT_W-1:0] bin_votes [ROWS*R_BINS];
    int             spread_cfg = SPREAD_RESET;
    bin_result_t    expected_bins [$];
    int             recent_hits [$];
    int             errors = 0;

    // Q2.14 sine, first quadrant mirrored over the full turn
    function int sin_fix(int a);
      int k;
      int v;
      k = a & 63;
      if (a & 64) k = 64 - k;
      v = int'(16384.0 * $sin(PI * k / 128.0));
      return (a & 128) ? -v : v;
    endfunction

    // floor((x*cos + y*sin) / 2^14)
    function int radius_of(int x, int y, int t);
      int s;
      s = x * sin_fix(t + 64) + y * sin_fix(t);
      return s >>> Q_SHIFT;
    endfunction

    function void take_item(logic [1:0] mode, int x, int y, logic [7:0] ang,
                            logic [8:0] rbin);
      bin_result_t res;
      int first, r0, r1, lo, hi, row, ri, addr;
      res.count     = '0;
      res.saturated = 1'b0;
      case (mode)
        MODE_VOTE: begin
          first = (int'(ang) - spread_cfg) & 255;
          r0 = radius_of(x, y, first);
          for (int i = 0; i < 2 * spread_cfg + 1; i++) begin
            row = (first + i) & 255;
            r1  = radius_of(x, y, row + 1);
            lo  = (r0 < r1) ? r0 : r1;
            hi  = (r0 < r1) ? r1 : r0;
            for (int r = lo; r <= hi; r++) begin
              ri = r + HALF_BINS;
              if (ri >= 0 && ri < R_BINS) begin
                addr = row * R_BINS + ri;
                if (bin_votes[addr] == COUNT_MAX) res.saturated = 1'b1;
                else bin_votes[addr] = bin_votes[addr] + 1'b1;
                recent_hits = {recent_hits, addr};
                if (recent_hits.size() > HIT_DEPTH) recent_hits.delete(0);
              end
            end
            r0 = r1;
          end
        end
        MODE_READ: begin
          res.count = bin_votes[int'(ang) * R_BINS + int'(rbin)];
        end
        MODE_CLEAR: begin
          foreach (bin_votes[a]) bin_votes[a] = '0;
        end
        default: ;
      endcase
      expected_bins = {expected_bins, res};
    endfunction

    function void check_result(logic [CNT_W-1:0] count, logic sat);
      bin_result_t want;
      if (expected_bins.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got bin_count %0d saturated %0b",
                 $time, count, sat);
        return;
      end
      want = expected_bins.pop_front();
      if (count !== want.count) begin
        errors++;
        $display("%0t: bin_count mismatch, expected %0d, got %0d", $time, want.count, count);
      end
      if (sat !== want.saturated) begin
        errors++;
        $display("%0t: saturated mismatch, expected %0b, got %0b", $time, want.saturated, sat);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                angle_spread_we;
  logic [SPREAD_W-1:0] angle_spread_wdata;
  logic                quiet;
  int                  idle_cycles = 0;
  accum_scoreboard     sb = new();

  hva_item_if   item_ch ();
  hva_result_if res_ch ();

  hough_vote_accumulator_core i_dut (
    .clk                (clk),
    .rst                (rst),
    .item               (item_ch),
    .result             (res_ch),
    .angle_spread_we    (angle_spread_we),
    .angle_spread_wdata (angle_spread_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Input and result monitors
  always @(posedge clk) begin
    if (!rst && item_ch.valid && item_ch.ready)
      sb.take_item(item_ch.mode, item_ch.point_x, item_ch.point_y, item_ch.angle,
                   item_ch.radius_bin);
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.bin_count, res_ch.saturated);
  end

  // Watchdog on cycles without any item moving
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_idle();
    return quiet ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // Result side: random stall before taking each result
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  // Present one item, hold until taken, then maybe idle
  task automatic send_item(input logic [1:0] mode, input logic signed [8:0] px,
                           input logic signed [8:0] py, input logic [7:0] ang,
                           input logic [8:0] rbin);
    int gap;
    item_ch.valid      <= 1'b1;
    item_ch.mode       <= mode;
    item_ch.point_x    <= px;
    item_ch.point_y    <= py;
    item_ch.angle      <= ang;
    item_ch.radius_bin <= rbin;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    gap = draw_idle();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bins.size() != 0) @(posedge clk);
  endtask

  task automatic write_spread(input int value);
    angle_spread_we    <= 1'b1;
    angle_spread_wdata <= SPREAD_W'(value);
    @(posedge clk);
    angle_spread_we    <= 1'b0;
    sb.spread_cfg = value;
  endtask

  // Coordinates: corners, origin, a small cluster, or anything
  function automatic logic signed [8:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 9'h100;
      1:       return 9'h0FF;
      2:       return 9'h000;
      3:       return 9'($urandom_range(0, 40) - 20);
      default: return 9'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n);
    int sel;
    int addr;
    int taken;
    int i;
    taken = 0;
    i = 0;
    while (taken < n) begin
      // every 40 items, sometimes run a stretch with no idling at all
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      i++;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_item(MODE_VOTE, pick_coord(), pick_coord(), 8'($urandom), 9'($urandom));
        taken++;
      end else if (sel < 90) begin
        if (sb.recent_hits.size() > 0 && $urandom_range(0, 2) != 0) begin
          addr = sb.recent_hits[$urandom_range(0, sb.recent_hits.size() - 1)];
          send_item(MODE_READ, 9'($urandom), 9'($urandom), 8'(addr / R_BINS),
                    9'(addr % R_BINS));
        end else begin
          send_item(MODE_READ, 9'($urandom), 9'($urandom), 8'($urandom), 9'($urandom));
        end
        taken++;
      end else begin
        send_item(MODE_UNUSED, 9'($urandom), 9'($urandom), 8'($urandom), 9'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // Stimulus
  initial begin
    int addr;
    rst                <= 1'b1;
    item_ch.valid      <= 1'b0;
    item_ch.mode       <= MODE_VOTE;
    item_ch.point_x    <= '0;
    item_ch.point_y    <= '0;
    item_ch.angle      <= '0;
    item_ch.radius_bin <= '0;
    angle_spread_we    <= 1'b0;
    angle_spread_wdata <= '0;
    quiet = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset spread: empty store, origin, corners, row wraparound, unused mode
    send_item(MODE_READ, 9'h000, 9'h000, 8'd0, 9'd256);
    send_item(MODE_VOTE, 9'h000, 9'h000, 8'd0, 9'd0);
    send_item(MODE_READ, 9'h000, 9'h000, 8'd0, 9'd256);
    send_item(MODE_VOTE, 9'h0FF, 9'h0FF, 8'd255, 9'h1FF);
    send_item(MODE_VOTE, 9'h100, 9'h100, 8'd128, 9'd0);
    send_item(MODE_VOTE, 9'h100, 9'h0FF, 8'd64, 9'd0);
    send_item(MODE_VOTE, 9'h0FF, 9'h100, 8'd192, 9'd0);
    send_item(MODE_READ, 9'h100, 9'h0FF, 8'd255, 9'd511);
    send_item(MODE_READ, 9'h000, 9'h000, 8'd0, 9'd0);
    send_item(MODE_UNUSED, 9'h0AA, 9'h155, 8'hA5, 9'h0AA);
    wait_idle();

    // Repeated votes: origin with spread 0 lands in one bin of one row
    write_spread(0);
    quiet = 1'b1;
    repeat (FILL_VOTES) send_item(MODE_VOTE, 9'h000, 9'h000, 8'(FILL_ROW), 9'd0);
    send_item(MODE_READ, 9'h000, 9'h000, 8'(FILL_ROW), 9'd256);
    wait_idle();
    // neighbor rows pick up votes once the spread widens
    write_spread(1);
    send_item(MODE_VOTE, 9'h000, 9'h000, 8'(FILL_ROW), 9'd0);
    send_item(MODE_READ, 9'h000, 9'h000, 8'(FILL_ROW), 9'd256);
    send_item(MODE_READ, 9'h000, 9'h000, 8'(FILL_ROW - 1), 9'd256);
    quiet = 1'b0;
    send_item(MODE_CLEAR, 9'h155, 9'h0AA, 8'h5A, 9'h155);
    send_item(MODE_READ, 9'h000, 9'h000, 8'(FILL_ROW), 9'd256);
    wait_idle();

    // Widest spread, corners with wraparound
    write_spread(31);
    send_item(MODE_VOTE, 9'h100, 9'h100, 8'd0, 9'd0);
    send_item(MODE_VOTE, 9'h0FF, 9'h0FF, 8'd200, 9'd0);
    addr = sb.recent_hits[0];
    send_item(MODE_READ, 9'h000, 9'h000, 8'(addr / R_BINS), 9'(addr % R_BINS));
    wait_idle();

    // Random phases, each under its own spread
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_spread(0);
        3:       write_spread(31);
        default: write_spread($urandom_range(0, 31));
      endcase
      random_phase(PHASE_ITEMS);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bins.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
